>>> src/acr_pkg.sv
// ============================================================================
// acr_pkg: shared definitions for the box collision resolver
// Field widths, item operation codes, register indexes and reset values.
// ============================================================================
`default_nettype none

package acr_pkg;

    // Signed Q16.4 coordinates and velocities, unsigned Q15.4 sizes.
    localparam int COORD_W = 20;
    localparam int SIZE_W  = 19;

    // Configuration register index width (two registers).
    localparam int REG_IDX_W = 1;

    // Item operation codes.
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_WALL  = 1'b1;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_BOX_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_HEIGHT = 1'b1;

    // Register reset values: a 100 by 120 pixel box.
    localparam logic [SIZE_W-1:0] BOX_WIDTH_RST  = 19'd1600;
    localparam logic [SIZE_W-1:0] BOX_HEIGHT_RST = 19'd1920;

endpackage

`default_nettype wire

>>> src/aabb_collision_resolve.sv
// ============================================================================
// aabb_collision_resolve: moving box against a stream of walls
// Resolves one moving box against the walls of a frame and emits the moved
// box, its velocity and the grounded flag after the frame's last item.
// ============================================================================
// An item is registered at acceptance and resolved from the input register; a
// last item's result then goes through the result register to the m_ side.
// Throughput: one item per cycle. A last item waits in the input register only
// while the result register holds a result that is not taken in that cycle.
// Reset (aresetn low, synchronous): both valid flags clear, the box state goes
// to zero and the box size registers return to 1600 by 1920 (Q15.4).
`default_nettype none

module aabb_collision_resolve (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [acr_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [acr_pkg::SIZE_W-1:0]           cfg_wdata,

    // Input item channel.
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_op,
    input  wire logic signed [acr_pkg::COORD_W-1:0]   s_start_x,
    input  wire logic signed [acr_pkg::COORD_W-1:0]   s_start_y,
    input  wire logic signed [acr_pkg::COORD_W-1:0]   s_start_vel_x,
    input  wire logic signed [acr_pkg::COORD_W-1:0]   s_start_vel_y,
    input  wire logic signed [acr_pkg::COORD_W-1:0]   s_wall_left,
    input  wire logic signed [acr_pkg::COORD_W-1:0]   s_wall_top,
    input  wire logic [acr_pkg::SIZE_W-1:0]           s_wall_width,
    input  wire logic [acr_pkg::SIZE_W-1:0]           s_wall_height,
    input  wire logic                                 s_last_item,

    // Result item channel.
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [acr_pkg::COORD_W-1:0]        m_final_x,
    output logic signed [acr_pkg::COORD_W-1:0]        m_final_y,
    output logic signed [acr_pkg::COORD_W-1:0]        m_final_vel_x,
    output logic signed [acr_pkg::COORD_W-1:0]        m_final_vel_y,
    output logic                                      m_can_jump
);

    typedef logic signed [acr_pkg::COORD_W-1:0] coord_t;

    function automatic coord_t smin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t smax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

    // ------------------------------------------------------------------
    // Config registers. User must write only while block is idle; unenforced.
    // ------------------------------------------------------------------
    logic [acr_pkg::SIZE_W-1:0] box_width_reg;
    logic [acr_pkg::SIZE_W-1:0] box_height_reg;

    // ------------------------------------------------------------------
    // Input register stage.
    // ------------------------------------------------------------------
    logic                        in_valid_reg;
    logic                        in_op_reg;
    coord_t                      in_start_x_reg;
    coord_t                      in_start_y_reg;
    coord_t                      in_start_vel_x_reg;
    coord_t                      in_start_vel_y_reg;
    coord_t                      in_wall_left_reg;
    coord_t                      in_wall_top_reg;
    logic [acr_pkg::SIZE_W-1:0]  in_wall_width_reg;
    logic [acr_pkg::SIZE_W-1:0]  in_wall_height_reg;
    logic                        in_last_reg;

    // Box state carried from item to item.
    coord_t box_x_reg,  box_x_next;
    coord_t box_y_reg,  box_y_next;
    coord_t vel_x_reg,  vel_x_next;
    coord_t vel_y_reg,  vel_y_next;
    logic   grounded_reg, grounded_next;

    // Result register stage.
    logic   m_valid_reg;
    coord_t m_final_x_reg;
    coord_t m_final_y_reg;
    coord_t m_final_vel_x_reg;
    coord_t m_final_vel_y_reg;
    logic   m_can_jump_reg;

    // The registered item moves on unless it produces a result and the
    // result register still holds one that is not being taken.
    logic proceed;
    logic out_load;

    assign proceed  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign out_load = proceed && in_last_reg;
    assign s_ready  = aresetn && (!in_valid_reg || proceed);

    // ------------------------------------------------------------------
    // Wall resolution against the current box. All sums wrap to 20 bits.
    // ------------------------------------------------------------------
    coord_t pw, ph, ww, wh;
    coord_t px, py, pr, pb;
    coord_t wl, wt, wrt, wbt;
    coord_t nx, ny, nr, nb;
    coord_t il, ir, it, ib;
    logic   hit, hov, vov;
    logic   bottom_hit, top_hit, left_hit, right_hit;

    assign pw  = coord_t'({1'b0, box_width_reg});
    assign ph  = coord_t'({1'b0, box_height_reg});
    assign ww  = coord_t'({1'b0, in_wall_width_reg});
    assign wh  = coord_t'({1'b0, in_wall_height_reg});

    assign px  = box_x_reg;
    assign py  = box_y_reg;
    assign pr  = px + pw;
    assign pb  = py + ph;
    assign wl  = in_wall_left_reg;
    assign wt  = in_wall_top_reg;
    assign wrt = wl + ww;
    assign wbt = wt + wh;

    // Box displaced by this frame's velocity.
    assign nx  = px + vel_x_reg;
    assign ny  = py + vel_y_reg;
    assign nr  = nx + pw;
    assign nb  = ny + ph;

    // Intersection of the two spans on each axis; each span runs from the
    // smaller to the larger of an edge and its wrapped far edge.
    assign il  = smax(smin(nx, nr), smin(wl, wrt));
    assign ir  = smin(smax(nx, nr), smax(wl, wrt));
    assign it  = smax(smin(ny, nb), smin(wt, wbt));
    assign ib  = smin(smax(ny, nb), smax(wt, wbt));
    assign hit = (il < ir) && (it < ib);

    // Overlaps of the undisplaced box, used to pick the contact side.
    assign hov = (px < wrt) && (pr > wl);
    assign vov = (py < wbt) && (pb > wt);

    assign bottom_hit = hit && (py <= wt) && (pb < wbt) && hov;
    assign top_hit    = hit && !bottom_hit && (py > wt) && (pb > wbt) && hov;
    assign left_hit   = hit && (px < wl) && (pr < wrt) && vov;
    assign right_hit  = hit && !left_hit && (px > wl) && (pr > wrt) && vov;

    // ------------------------------------------------------------------
    // Next box state.
    // ------------------------------------------------------------------
    always_comb begin
        box_x_next    = box_x_reg;
        box_y_next    = box_y_reg;
        vel_x_next    = vel_x_reg;
        vel_y_next    = vel_y_reg;
        grounded_next = grounded_reg;

        if (proceed) begin
            if (in_op_reg == acr_pkg::OP_BEGIN) begin
                box_x_next    = in_start_x_reg;
                box_y_next    = in_start_y_reg;
                vel_x_next    = in_start_vel_x_reg;
                vel_y_next    = in_start_vel_y_reg;
                grounded_next = 1'b0;
            end else begin
                // Vertical contact first: landing on the wall snaps the box
                // onto its top; hitting it from below snaps under it.
                if (bottom_hit) begin
                    vel_y_next    = '0;
                    box_y_next    = wt - ph;
                    grounded_next = 1'b1;
                end else if (top_hit) begin
                    vel_y_next = '0;
                    box_y_next = wbt;
                end
                // A side contact puts the box beside the wall and keeps the
                // top it had before this wall.
                if (left_hit) begin
                    vel_x_next = '0;
                    box_x_next = wl - pw;
                    box_y_next = py;
                end else if (right_hit) begin
                    vel_x_next = '0;
                    box_x_next = wrt;
                    box_y_next = py;
                end
            end

            // The frame's last item moves the box by the resolved velocity.
            if (in_last_reg) begin
                box_x_next = box_x_next + vel_x_next;
                box_y_next = box_y_next + vel_y_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_width_reg  <= acr_pkg::BOX_WIDTH_RST;
            box_height_reg <= acr_pkg::BOX_HEIGHT_RST;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            box_x_reg      <= '0;
            box_y_reg      <= '0;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            grounded_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    acr_pkg::REG_BOX_WIDTH:  box_width_reg  <= cfg_wdata;
                    acr_pkg::REG_BOX_HEIGHT: box_height_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            box_x_reg    <= box_x_next;
            box_y_reg    <= box_y_next;
            vel_x_reg    <= vel_x_next;
            vel_y_reg    <= vel_y_next;
            grounded_reg <= grounded_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg          <= s_op;
            in_start_x_reg     <= s_start_x;
            in_start_y_reg     <= s_start_y;
            in_start_vel_x_reg <= s_start_vel_x;
            in_start_vel_y_reg <= s_start_vel_y;
            in_wall_left_reg   <= s_wall_left;
            in_wall_top_reg    <= s_wall_top;
            in_wall_width_reg  <= s_wall_width;
            in_wall_height_reg <= s_wall_height;
            in_last_reg        <= s_last_item;
        end
        if (out_load) begin
            m_final_x_reg     <= box_x_next;
            m_final_y_reg     <= box_y_next;
            m_final_vel_x_reg <= vel_x_next;
            m_final_vel_y_reg <= vel_y_next;
            m_can_jump_reg    <= grounded_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_final_x     = m_final_x_reg;
    assign m_final_y     = m_final_y_reg;
    assign m_final_vel_x = m_final_vel_x_reg;
    assign m_final_vel_y = m_final_vel_y_reg;
    assign m_can_jump    = m_can_jump_reg;

endmodule

`default_nettype wire

>>> src/acr_checker.sv
// ============================================================================
// acr_checker: port-level checks for the box collision resolver
// Watches the item channels and flags ordering and result errors.
// ============================================================================
`default_nettype none

module acr_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 s_op,
    input wire logic signed [acr_pkg::COORD_W-1:0]   s_start_x,
    input wire logic signed [acr_pkg::COORD_W-1:0]   s_start_y,
    input wire logic signed [acr_pkg::COORD_W-1:0]   s_start_vel_x,
    input wire logic signed [acr_pkg::COORD_W-1:0]   s_start_vel_y,
    input wire logic                                 s_last_item,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic signed [acr_pkg::COORD_W-1:0]   m_final_x,
    input wire logic signed [acr_pkg::COORD_W-1:0]   m_final_y,
    input wire logic signed [acr_pkg::COORD_W-1:0]   m_final_vel_x,
    input wire logic signed [acr_pkg::COORD_W-1:0]   m_final_vel_y,
    input wire logic                                 m_can_jump
);

    logic                                 begin_last_acc;
    logic signed [acr_pkg::COORD_W-1:0]   moved_x;
    logic signed [acr_pkg::COORD_W-1:0]   moved_y;

    assign begin_last_acc = s_valid && s_ready && s_last_item
                            && (s_op == acr_pkg::OP_BEGIN);
    assign moved_x = s_start_x + s_start_vel_x;
    assign moved_y = s_start_y + s_start_vel_y;

    // A waiting result stays and holds its value.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_final_x) && $stable(m_final_y)
            && $stable(m_final_vel_x) && $stable(m_final_vel_y) && $stable(m_can_jump))
        else $error("result changed or dropped while stalled");

    // A new result follows an accepted last item through the input and result registers.
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last_item, 2))
        else $error("result without a matching last item");

    // A frame without walls just moves the box and is never grounded.
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        begin_last_acc ##1 (!m_valid || m_ready) |=> m_valid && !m_can_jump
            && m_final_x == $past(moved_x, 2) && m_final_y == $past(moved_y, 2)
            && m_final_vel_x == $past(s_start_vel_x, 2)
            && m_final_vel_y == $past(s_start_vel_y, 2))
        else $error("wall-free frame result is wrong");

    // The input stage never refuses an item while the output side is empty.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !$past(s_valid && s_ready) |-> s_ready)
        else $error("input stalled with nothing pending");

endmodule

bind aabb_collision_resolve acr_checker u_acr_checker (.*);

`default_nettype wire
